// ----- hw/rtl/lzsd_pkg.sv -----
// lzsd_pkg: shared constants and types for the seven-command LZ decompressor.
// Used by lzsd_ctrl and lz_seven_command_decompressor_top; no dependencies.
package lzsd_pkg;

  // Default size of the output history store in bytes
  localparam int STORE_BYTES_DEF = 4096;

  // Item kinds on the feed channel
  localparam logic FUNC_FEED = 1'b0;
  localparam logic FUNC_PULL = 1'b1;

  // Command byte markers
  localparam logic [7:0] CMD_END  = 8'hFF;
  localparam logic [7:0] CMD_BAD  = 8'hFC;
  localparam logic [7:0] CMD_LONG = 8'hE0;
  localparam logic [7:0] REF_BIAS = 8'd127;

  // Command kinds
  localparam logic [2:0] KIND_LIT  = 3'd0;
  localparam logic [2:0] KIND_FILL = 3'd1;
  localparam logic [2:0] KIND_PAIR = 3'd2;
  localparam logic [2:0] KIND_ZERO = 3'd3;
  localparam logic [2:0] KIND_COPY = 3'd4;
  localparam logic [2:0] KIND_REV  = 3'd5;
  localparam logic [2:0] KIND_BACK = 3'd6;

  // Error codes
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_CMD       = 3'd1;
  localparam logic [2:0] ERR_OVERFLOW  = 3'd2;
  localparam logic [2:0] ERR_REF       = 3'd3;
  localparam logic [2:0] ERR_UNDERFLOW = 3'd4;
  localparam logic [2:0] ERR_KIND      = 3'd5;

  // Per-beat control handed from the parser to the store pipeline
  typedef struct packed {
    logic       produce;     // beat emits a byte and writes the store
    logic       from_store;  // byte comes from a store read
    logic       reverse;     // bit-reverse the store byte
    logic [7:0] data;        // literal or fill byte when not from the store
    logic       need_input;
    logic       done;
    logic [2:0] error;
  } issue_t;

endpackage

// ----- hw/rtl/lzsd_if.sv -----
// lzsd_if: valid/ready channel interfaces for the decompressor feed and result.
// Depends on nothing.
interface lzsd_feed_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] data_byte;

  modport source (output valid, func, data_byte, input ready);
  modport sink   (input valid, func, data_byte, output ready);
endinterface

interface lzsd_result_if;
  logic        valid;
  logic        ready;
  logic        out_valid;
  logic [7:0]  out_byte;
  logic [12:0] out_count;
  logic        need_input;
  logic        done_res;
  logic [2:0]  error;

  modport source (output valid, out_valid, out_byte, out_count, need_input, done_res, error,
                  input ready);
  modport sink   (input valid, out_valid, out_byte, out_count, need_input, done_res, error,
                  output ready);
endinterface

// ----- hw/rtl/lzsd_ram.sv -----
// lzsd_ram: generic single-write, single-read RAM with registered read data.
// Read data holds while re is low; a same-address write returns old data.
module lzsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/lzsd_ctrl.sv -----
// lzsd_ctrl: command parser and run sequencer; one decision per accepted beat.
// Depends on lzsd_pkg. Drives store addresses and per-beat control to the top.
module lzsd_ctrl #(
  parameter int STORE_BYTES = lzsd_pkg::STORE_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           accept,
  input  logic                           func,
  input  logic [7:0]                     data_byte,
  output lzsd_pkg::issue_t               issue,
  output logic [$clog2(STORE_BYTES)-1:0] rd_addr,
  output logic [$clog2(STORE_BYTES)-1:0] wr_addr,
  output logic [12:0]                    count
);

  localparam int AW   = $clog2(STORE_BYTES);
  localparam int PW   = $clog2(STORE_BYTES + 1);
  localparam int SUMW = ((PW > 11) ? PW : 11) + 1;
  localparam int CW   = ((PW > 16) ? PW : 16) + 1;

  typedef enum logic [3:0] {
    PH_CMD, PH_LEN2, PH_REF1, PH_REF2, PH_FILL, PH_PAIR1, PH_PAIR2,
    PH_LIT, PH_RUN, PH_DONE, PH_ERR
  } phase_t;

  phase_t        phase, phase_next;
  logic [2:0]    kind, kind_next;
  logic [10:0]   run, run_next, run_dec;
  logic [15:0]   src, src_next;
  logic [15:0]   fill, fill_next;
  logic [PW-1:0] wp, wp_next;
  logic [2:0]    err, err_next;
  logic          done_flag, done_next;
  logic          put, len_chk, ref_chk;
  logic          from_store, reverse;
  logic [7:0]    byte_val;

  // Next-state decode for one beat
  always_comb begin
    phase_next = phase;
    kind_next  = kind;
    run_next   = run;
    src_next   = src;
    fill_next  = fill;
    wp_next    = wp;
    err_next   = err;
    done_next  = done_flag;
    put        = 1'b0;
    len_chk    = 1'b0;
    ref_chk    = 1'b0;
    from_store = 1'b0;
    reverse    = 1'b0;
    byte_val   = 8'd0;
    run_dec    = run;

    case (phase)
      PH_ERR, PH_DONE: begin
        // ignored
      end
      PH_RUN: begin
        if (func != lzsd_pkg::FUNC_PULL) begin
          err_next   = lzsd_pkg::ERR_KIND;
          phase_next = PH_ERR;
        end else begin
          put = 1'b1;
          case (kind)
            lzsd_pkg::KIND_PAIR: begin
              byte_val  = fill[15:8];
              fill_next = {fill[7:0], fill[15:8]};
            end
            lzsd_pkg::KIND_COPY, lzsd_pkg::KIND_REV: begin
              from_store = 1'b1;
              reverse    = (kind == lzsd_pkg::KIND_REV);
              src_next   = src + 16'd1;
            end
            lzsd_pkg::KIND_BACK: begin
              from_store = 1'b1;
              src_next   = src - 16'd1;
            end
            default: begin
              byte_val = fill[7:0];
            end
          endcase
        end
      end
      default: begin
        if (func != lzsd_pkg::FUNC_FEED) begin
          err_next   = lzsd_pkg::ERR_KIND;
          phase_next = PH_ERR;
        end else begin
          case (phase)
            PH_CMD: begin
              if (data_byte == lzsd_pkg::CMD_END) begin
                done_next  = 1'b1;
                phase_next = PH_DONE;
              end else if (data_byte >= lzsd_pkg::CMD_BAD) begin
                err_next   = lzsd_pkg::ERR_CMD;
                phase_next = PH_ERR;
              end else if (data_byte >= lzsd_pkg::CMD_LONG) begin
                kind_next  = data_byte[4:2];
                run_next   = {9'd0, data_byte[1:0]};
                phase_next = PH_LEN2;
              end else begin
                kind_next = data_byte[7:5];
                run_next  = {6'd0, data_byte[4:0]} + 11'd1;
                len_chk   = 1'b1;
              end
            end
            PH_LEN2: begin
              run_next = {1'b0, run[1:0], data_byte} + 11'd1;
              len_chk  = 1'b1;
            end
            PH_REF1: begin
              if (data_byte[7]) begin
                src_next = 16'(wp) - {8'd0, data_byte - lzsd_pkg::REF_BIAS};
                ref_chk  = 1'b1;
              end else begin
                src_next   = {data_byte, 8'd0};
                phase_next = PH_REF2;
              end
            end
            PH_REF2: begin
              src_next = {src[15:8], data_byte};
              ref_chk  = 1'b1;
            end
            PH_FILL: begin
              fill_next  = {8'd0, data_byte};
              phase_next = PH_RUN;
            end
            PH_PAIR1: begin
              fill_next  = {data_byte, 8'd0};
              phase_next = PH_PAIR2;
            end
            PH_PAIR2: begin
              fill_next  = {fill[15:8], data_byte};
              phase_next = PH_RUN;
            end
            default: begin
              // literal run byte
              put      = 1'b1;
              byte_val = data_byte;
            end
          endcase
        end
      end
    endcase

    // Run length known: bound check, then branch on kind
    if (len_chk) begin
      if ((SUMW'(wp) + SUMW'(run_next)) > SUMW'(STORE_BYTES)) begin
        err_next   = lzsd_pkg::ERR_OVERFLOW;
        phase_next = PH_ERR;
      end else begin
        case (kind_next)
          lzsd_pkg::KIND_LIT:  phase_next = PH_LIT;
          lzsd_pkg::KIND_FILL: phase_next = PH_FILL;
          lzsd_pkg::KIND_PAIR: phase_next = PH_PAIR1;
          lzsd_pkg::KIND_ZERO: begin
            fill_next  = 16'd0;
            phase_next = PH_RUN;
          end
          default:             phase_next = PH_REF1;
        endcase
      end
    end

    // Copy source known: must lie in written data
    if (ref_chk) begin
      if (CW'(src_next) >= CW'(wp)) begin
        err_next   = lzsd_pkg::ERR_REF;
        phase_next = PH_ERR;
      end else if (kind == lzsd_pkg::KIND_BACK && 17'(run) > (17'(src_next) + 17'd1)) begin
        err_next   = lzsd_pkg::ERR_UNDERFLOW;
        phase_next = PH_ERR;
      end else begin
        phase_next = PH_RUN;
      end
    end

    // Byte produced: advance position, count down run
    if (put) begin
      wp_next  = wp + PW'(1);
      run_dec  = run - ((run != 11'd0) ? 11'd1 : 11'd0);
      run_next = run_dec;
      if (run_dec == 11'd0) begin
        phase_next = PH_CMD;
      end
    end
  end

  // Beat control and store addresses
  always_comb begin
    issue.produce    = put;
    issue.from_store = from_store;
    issue.reverse    = reverse;
    issue.data       = byte_val;
    issue.need_input = !(phase_next inside {PH_RUN, PH_DONE, PH_ERR});
    issue.done       = done_next;
    issue.error      = err_next;
  end

  assign rd_addr = AW'(src);
  assign wr_addr = AW'(wp);
  assign count   = 13'(wp_next);

  // Parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_CMD;
      kind      <= lzsd_pkg::KIND_LIT;
      run       <= '0;
      src       <= '0;
      fill      <= '0;
      wp        <= '0;
      err       <= lzsd_pkg::ERR_NONE;
      done_flag <= 1'b0;
    end else if (accept) begin
      phase     <= phase_next;
      kind      <= kind_next;
      run       <= run_next;
      src       <= src_next;
      fill      <= fill_next;
      wp        <= wp_next;
      err       <= err_next;
      done_flag <= done_next;
    end
  end

endmodule

// ----- hw/rtl/lz_seven_command_decompressor_top.sv -----
// lz_seven_command_decompressor_top: seven-command LZ decompressor top level.
// Depends on lzsd_pkg, lzsd_if, lzsd_ram and lzsd_ctrl.
//
//   channel  role  handshake      payload
//   stream   sink  valid / ready  func, data_byte
//   result   src   valid / ready  out_valid, out_byte, out_count, need_input,
//                                 done_res, error
//
// One beat in, one beat out; a new beat is taken every cycle while results drain.
// In order, the parser issues the history store read and the read stage
// picks the byte (store, forwarded write or literal), writes it back and fills the
// output register. One read and one write port of the store set the pace.
// Reset is synchronous; the store itself is not cleared, copies only read bytes
// already written. A stalled result holds the read stage, which holds the input.
module lz_seven_command_decompressor_top #(
  parameter int STORE_BYTES = lzsd_pkg::STORE_BYTES_DEF
) (
  input logic          clk,
  input logic          rst,
  lzsd_feed_if.sink    stream,
  lzsd_result_if.source result
);

  localparam int AW = $clog2(STORE_BYTES);

  function automatic logic [7:0] bit_rev(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = v[7 - i];
    end
    return r;
  endfunction

  lzsd_pkg::issue_t issue;
  logic [AW-1:0]    rd_addr, wr_addr;
  logic [12:0]      count;
  logic             accept, in_ready, s1_move;

  // Read stage registers
  logic             s1_valid;
  lzsd_pkg::issue_t s1_ctl;
  logic [AW-1:0]    s1_wr_addr;
  logic [12:0]      s1_count;
  logic             s1_fwd_hit;
  logic [7:0]       s1_fwd_data;
  logic [7:0]       ram_rdata, s1_raw, s1_byte;
  logic             ram_we;

  // Output register
  logic             res_valid;

  assign s1_move      = s1_valid && (!res_valid || result.ready);
  assign in_ready     = !s1_valid || s1_move;
  assign accept       = stream.valid && in_ready;
  assign stream.ready = in_ready;
  assign ram_we       = s1_move && s1_ctl.produce;

  lzsd_ctrl #(
    .STORE_BYTES(STORE_BYTES)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .func     (stream.func),
    .data_byte(stream.data_byte),
    .issue    (issue),
    .rd_addr  (rd_addr),
    .wr_addr  (wr_addr),
    .count    (count)
  );

  lzsd_ram #(
    .WIDTH(8),
    .DEPTH(STORE_BYTES)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(s1_wr_addr),
    .wdata(s1_byte),
    .re   (accept && issue.from_store),
    .raddr(rd_addr),
    .rdata(ram_rdata)
  );

  // Byte select; forward the write that landed in the same cycle as the read
  always_comb begin
    if (s1_ctl.from_store) begin
      s1_raw = s1_fwd_hit ? s1_fwd_data : ram_rdata;
    end else begin
      s1_raw = s1_ctl.data;
    end
    s1_byte = s1_ctl.reverse ? bit_rev(s1_raw) : s1_raw;
  end

  // Read stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept || (s1_valid && !s1_move);
    end
    if (accept) begin
      s1_ctl      <= issue;
      s1_wr_addr  <= wr_addr;
      s1_count    <= count;
      s1_fwd_hit  <= ram_we && (s1_wr_addr == rd_addr);
      s1_fwd_data <= s1_byte;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      res_valid <= s1_move || (res_valid && !result.ready);
    end
    if (s1_move) begin
      result.out_valid  <= s1_ctl.produce;
      result.out_byte   <= s1_ctl.produce ? s1_byte : 8'd0;
      result.out_count  <= s1_count;
      result.need_input <= s1_ctl.need_input;
      result.done_res   <= s1_ctl.done;
      result.error      <= s1_ctl.error;
    end
  end

  assign result.valid = res_valid;

  // A produced byte never comes with an error or after the end marker
  a_byte_clean: assert property (@(posedge clk) disable iff (rst)
    res_valid && result.out_valid |->
      result.error == lzsd_pkg::ERR_NONE && !result.done_res)
    else $error("byte produced with error or after end");

  // Copies only read bytes below the write position
  a_read_behind: assert property (@(posedge clk) disable iff (rst)
    accept && issue.from_store |-> rd_addr < wr_addr)
    else $error("store read at or past write position");

  // A stalled read stage keeps its beat
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_move |=> s1_valid && $stable(s1_count) && $stable(s1_wr_addr))
    else $error("read stage lost a stalled beat");

endmodule

// ----- tb/lz_seven_command_decompressor_top_tb.sv -----
// Self-checking testbench for lz_seven_command_decompressor_top: builds LZ streams, predicts
// every result beat with an in-bench decoder and checks the result channel against it.
// Depends on lzsd_pkg, lzsd_if and the decompressor RTL.
`timescale 1ns / 1ps

module lz_seven_command_decompressor_top_tb;

  localparam int STORE_BYTES    = lzsd_pkg::STORE_BYTES_DEF;
  localparam int AW             = $clog2(STORE_BYTES);
  localparam int ROOM_RESERVE   = 64;    // bytes kept free for the closing sequence
  localparam int HOLD_OFF_LEN   = 400;   // receiver hold-off in cycles
  localparam int WATCHDOG_LIMIT = 3000;  // cycles without any accepted beat
  localparam int DRAIN_CYCLES   = 8;
  localparam int PHASE_BEATS    = 150;

  // Decoder position within the compressed stream
  typedef enum logic [3:0] {
    AWAIT_CMD, AWAIT_LEN_LO, AWAIT_REF_HI, AWAIT_REF_LO, AWAIT_FILL, AWAIT_PAIR_A,
    AWAIT_PAIR_B, LITERAL_RUN, SELF_RUN, STREAM_DONE, STREAM_ERR
  } stream_phase_t;

  // Ways to close the stream
  typedef enum int {
    END_MARKER, END_BAD_CMD, END_OVERFLOW, END_BAD_REF, END_UNDERFLOW, END_WRONG_KIND
  } stream_end_t;

  typedef struct packed {
    logic        out_valid;
    logic [7:0]  out_byte;
    logic [12:0] out_count;
    logic        need_input;
    logic        done_res;
    logic [2:0]  error;
  } result_beat_t;

  logic clk;
  logic rst;

  lzsd_feed_if   stream ();
  lzsd_result_if result ();

  lz_seven_command_decompressor_top u_dut (
    .clk    (clk),
    .rst    (rst),
    .stream (stream),
    .result (result)
  );

  // Decoder state
  logic [7:0]    hist [STORE_BYTES];
  int            wr_pos;
  stream_phase_t phase;
  logic [2:0]    run_kind;
  int            run_left;
  logic [15:0]   src;
  logic [15:0]   pair;
  logic [2:0]    sticky_err;
  logic          done;

  result_beat_t  expected_beats [$];
  int            mismatches;
  int            stream_beats;  // beats not ignored by the block
  int            feed_idle_pct;
  int            result_stall_pct;
  bit            hold_off_req;

  // Clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Decoder
  // ---------------------------------------------------------------------------
  function automatic void fail_with(input logic [2:0] code);
    sticky_err = code;
    phase      = STREAM_ERR;
  endfunction

  // Length complete: check room, then pick what comes next
  function automatic void check_length();
    if (wr_pos + run_left > STORE_BYTES) begin
      fail_with(lzsd_pkg::ERR_OVERFLOW);
    end else if (run_kind >= lzsd_pkg::KIND_COPY) begin
      phase = AWAIT_REF_HI;
    end else begin
      case (run_kind)
        lzsd_pkg::KIND_LIT:  phase = LITERAL_RUN;
        lzsd_pkg::KIND_FILL: phase = AWAIT_FILL;
        lzsd_pkg::KIND_PAIR: phase = AWAIT_PAIR_A;
        default: begin
          pair  = 16'h0000;
          phase = SELF_RUN;
        end
      endcase
    end
  endfunction

  // Copy source complete: must point at written history
  function automatic void check_reference();
    if (int'(src) >= wr_pos) begin
      fail_with(lzsd_pkg::ERR_REF);
    end else if (run_kind == lzsd_pkg::KIND_BACK && run_left > int'(src) + 1) begin
      fail_with(lzsd_pkg::ERR_UNDERFLOW);
    end else begin
      phase = SELF_RUN;
    end
  endfunction

  function automatic void store_byte(input logic [7:0] v);
    if (wr_pos < STORE_BYTES) hist[wr_pos[AW-1:0]] = v;
    wr_pos++;
    if (run_left > 0) run_left--;
    if (run_left == 0) phase = AWAIT_CMD;
  endfunction

  function automatic result_beat_t predict_beat(input logic f, input logic [7:0] b);
    result_beat_t r;
    logic [7:0]   fetched;
    int           i;
    r       = '0;
    fetched = (int'(src) < STORE_BYTES) ? hist[src[AW-1:0]] : 8'h00;
    if (phase == STREAM_DONE || phase == STREAM_ERR) begin
      // everything ignored once the stream has ended
    end else if (phase == SELF_RUN) begin
      if (f != lzsd_pkg::FUNC_PULL) begin
        fail_with(lzsd_pkg::ERR_KIND);
      end else begin
        case (run_kind)
          lzsd_pkg::KIND_PAIR: begin
            pair       = {pair[7:0], pair[15:8]};
            r.out_byte = pair[7:0];
          end
          lzsd_pkg::KIND_COPY: begin
            r.out_byte = fetched;
            src        = src + 16'd1;
          end
          lzsd_pkg::KIND_REV: begin
            for (i = 0; i < 8; i++) r.out_byte[i] = fetched[7-i];
            src = src + 16'd1;
          end
          lzsd_pkg::KIND_BACK: begin
            r.out_byte = fetched;
            src        = src - 16'd1;
          end
          default: r.out_byte = pair[7:0];
        endcase
        r.out_valid = 1'b1;
        store_byte(r.out_byte);
      end
    end else if (f != lzsd_pkg::FUNC_FEED) begin
      fail_with(lzsd_pkg::ERR_KIND);
    end else begin
      case (phase)
        AWAIT_CMD: begin
          if (b == lzsd_pkg::CMD_END) begin
            done  = 1'b1;
            phase = STREAM_DONE;
          end else if (b >= lzsd_pkg::CMD_BAD) begin
            fail_with(lzsd_pkg::ERR_CMD);
          end else if (b >= lzsd_pkg::CMD_LONG) begin
            run_kind = b[4:2];
            run_left = int'(b[1:0]);
            phase    = AWAIT_LEN_LO;
          end else begin
            run_kind = b[7:5];
            run_left = int'(b[4:0]) + 1;
            check_length();
          end
        end
        AWAIT_LEN_LO: begin
          run_left = ((run_left & 3) << 8) + int'(b) + 1;
          check_length();
        end
        AWAIT_REF_HI: begin
          if (b[7]) begin
            src = 16'(wr_pos - (int'(b) - int'(lzsd_pkg::REF_BIAS)));
            check_reference();
          end else begin
            src   = {b, 8'h00};
            phase = AWAIT_REF_LO;
          end
        end
        AWAIT_REF_LO: begin
          src[7:0] = b;
          check_reference();
        end
        AWAIT_FILL: begin
          pair  = {8'h00, b};
          phase = SELF_RUN;
        end
        AWAIT_PAIR_A: begin
          pair  = {b, 8'h00};
          phase = AWAIT_PAIR_B;
        end
        AWAIT_PAIR_B: begin
          pair[7:0] = b;
          phase     = SELF_RUN;
        end
        default: begin  // literal run
          r.out_byte  = b;
          r.out_valid = 1'b1;
          store_byte(b);
        end
      endcase
    end
    r.out_count  = wr_pos[12:0];
    r.need_input = !(phase inside {SELF_RUN, STREAM_DONE, STREAM_ERR});
    r.done_res   = done;
    r.error      = sticky_err;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stream side
  // ---------------------------------------------------------------------------
  // Send one beat with random idle cycles ahead of it; predict on acceptance
  task automatic send_beat(input logic f, input logic [7:0] b);
    while ($urandom_range(99) < feed_idle_pct) begin
      stream.valid <= 1'b0;
      @(negedge clk);
    end
    stream.valid     <= 1'b1;
    stream.func      <= f;
    stream.data_byte <= b;
    @(posedge clk);
    while (!stream.ready) @(posedge clk);
    if (phase != STREAM_DONE && phase != STREAM_ERR) stream_beats++;
    expected_beats.push_back(predict_beat(f, b));
    @(negedge clk);
  endtask

  task automatic feed(input logic [7:0] b);
    send_beat(lzsd_pkg::FUNC_FEED, b);
  endtask

  task automatic pull();
    send_beat(lzsd_pkg::FUNC_PULL, 8'($urandom_range(255)));
  endtask

  // One well-formed command: header, then whatever the decoder asks for until it is
  // back at a command (or has failed on purpose)
  task automatic play_command(input logic [2:0] k, input int len, input bit long_form,
                              input bit short_ref, input int ref_src);
    logic [9:0] lm1;
    lm1 = 10'(len - 1);
    if (long_form) begin
      feed(lzsd_pkg::CMD_LONG | {3'b000, k, lm1[9:8]});
      feed(lm1[7:0]);
    end else begin
      feed({k, lm1[4:0]});
    end
    while (!(phase inside {AWAIT_CMD, STREAM_DONE, STREAM_ERR})) begin
      case (phase)
        AWAIT_REF_HI: begin
          if (short_ref) feed(8'(wr_pos - ref_src + int'(lzsd_pkg::REF_BIAS)));
          else feed(8'(ref_src >> 8));
        end
        AWAIT_REF_LO: feed(8'(ref_src));
        SELF_RUN:     pull();
        default:      feed(8'($urandom_range(255)));  // literal, fill and pair bytes
      endcase
    end
  endtask

  // Random command, sized to stay inside the store
  task automatic play_random_command();
    logic [2:0] k;
    int         len;
    int         room;
    int         pick;
    int         src_pos;
    int         off;
    bit         short_ref;
    bit         long_form;
    k = 3'($urandom_range(6));
    if (wr_pos == 0 && k >= lzsd_pkg::KIND_COPY) k = 3'($urandom_range(3));
    room = STORE_BYTES - ROOM_RESERVE - wr_pos;
    pick = $urandom_range(99);
    if (pick < 1 && wr_pos + 1024 <= 3000) len = $urandom_range(1024, 768);
    else if (pick < 10) len = $urandom_range(96, 33);
    else if (pick < 45) len = $urandom_range(32, 1);
    else len = $urandom_range(6, 1);
    if (len > room) len = room;
    if (len < 1) len = 1;
    short_ref = 1'b0;
    src_pos   = 0;
    if (k >= lzsd_pkg::KIND_COPY) begin
      if ($urandom_range(1)) begin
        short_ref = 1'b1;
        off       = $urandom_range((wr_pos < 128) ? wr_pos : 128, 1);
        src_pos   = wr_pos - off;
      end else begin
        src_pos = $urandom_range(wr_pos - 1, 0);
      end
      if (k == lzsd_pkg::KIND_BACK && len > src_pos + 1) len = src_pos + 1;
    end
    long_form = (len > 32) || ($urandom_range(4) == 0);
    play_command(k, len, long_form, short_ref, src_pos);
  endtask

  task automatic set_idling(input int idle_pct, input int stall_pct);
    feed_idle_pct    = idle_pct;
    result_stall_pct = stall_pct;
  endtask

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------
  // Receiver: random stalls, or a long hold-off when requested
  initial begin
    result.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        repeat (HOLD_OFF_LEN) begin
          result.ready <= 1'b0;
          @(negedge clk);
        end
      end
      result.ready <= ($urandom_range(99) >= result_stall_pct);
    end
  end

  task automatic compare_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Check every result beat against the oldest prediction
  always @(posedge clk) begin
    result_beat_t want;
    if (!rst && result.valid && result.ready) begin
      if (expected_beats.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual byte 0x%0h count %0d",
                 $time, result.out_byte, result.out_count);
        mismatches++;
      end else begin
        want = expected_beats.pop_front();
        compare_field("out_valid", 16'(want.out_valid), 16'(result.out_valid));
        compare_field("out_byte", 16'(want.out_byte), 16'(result.out_byte));
        compare_field("out_count", 16'(want.out_count), 16'(result.out_count));
        compare_field("need_input", 16'(want.need_input), 16'(result.need_input));
        compare_field("done_res", 16'(want.done_res), 16'(result.done_res));
        compare_field("error", 16'(want.error), 16'(result.error));
      end
    end
  end

  // Watchdog: too long without any accepted beat on either channel
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((stream.valid && stream.ready) || (result.valid && result.ready)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no beat accepted for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("lz_seven_command_decompressor_top_tb NOT OK");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Every command kind once, both length forms, both reference forms, byte extremes
  task automatic test_directed();
    set_idling(0, 0);
    feed({lzsd_pkg::KIND_LIT, 5'd1});
    feed(8'h00);
    feed(8'hFF);
    play_command(lzsd_pkg::KIND_FILL, 2, 1'b1, 1'b0, 0);
    play_command(lzsd_pkg::KIND_PAIR, 3, 1'b0, 1'b0, 0);
    play_command(lzsd_pkg::KIND_ZERO, 1, 1'b0, 1'b0, 0);
    play_command(lzsd_pkg::KIND_COPY, 3, 1'b0, 1'b1, wr_pos - 1);  // overlapping copy
    play_command(lzsd_pkg::KIND_REV, 2, 1'b0, 1'b0, 0);
    play_command(lzsd_pkg::KIND_BACK, 2, 1'b0, 1'b1, wr_pos - 1);
  endtask

  // Random well-formed commands under each idling mix
  task automatic test_random_stream();
    int target;
    int mode;
    for (mode = 0; mode < 4; mode++) begin
      case (mode)
        0:       set_idling(0, 0);
        1:       set_idling(76, 0);
        2:       set_idling(0, 76);
        default: set_idling(27, 27);
      endcase
      target = stream_beats + PHASE_BEATS;
      while (stream_beats < target) play_random_command();
    end
  endtask

  // Receiver holds off while the sender keeps offering
  task automatic test_backpressure();
    int target;
    set_idling(0, 0);
    hold_off_req = 1'b1;
    target = stream_beats + 80;
    while (stream_beats < target) play_random_command();
  endtask

  // Close the stream one way, then check that later beats are ignored
  task automatic test_stream_end();
    stream_end_t ending;
    logic [15:0] idx;
    logic [2:0]  k;
    int          len;
    int          src_pos;
    int          pick;
    set_idling(27, 27);
    ending = stream_end_t'($urandom_range(5));
    case (ending)
      END_MARKER:  feed(lzsd_pkg::CMD_END);
      END_BAD_CMD: feed(8'($urandom_range(8'hFE, lzsd_pkg::CMD_BAD)));
      END_OVERFLOW: begin
        // fill the store to the last byte, then ask for one more
        while (wr_pos < STORE_BYTES) begin
          len = STORE_BYTES - wr_pos;
          if (len > 1024) len = 1024;
          play_command($urandom_range(1) ? lzsd_pkg::KIND_ZERO : lzsd_pkg::KIND_FILL, len,
                       1'b1, 1'b0, 0);
        end
        feed({3'($urandom_range(6)), 5'd0});
      end
      END_BAD_REF: begin
        k = 3'($urandom_range(lzsd_pkg::KIND_BACK, lzsd_pkg::KIND_COPY));
        feed({k, 5'd0});
        if (wr_pos < 128 && $urandom_range(1)) begin
          feed(8'(int'(lzsd_pkg::REF_BIAS) + $urandom_range(128, wr_pos + 1)));
        end else begin
          idx = $urandom_range(1) ? 16'(wr_pos) : 16'($urandom_range(16'h7FFF, wr_pos));
          feed(idx[15:8]);
          feed(idx[7:0]);
        end
      end
      END_UNDERFLOW: begin
        src_pos = $urandom_range((wr_pos - 1 < 30) ? wr_pos - 1 : 30, 0);
        len     = $urandom_range(32, src_pos + 2);
        play_command(lzsd_pkg::KIND_BACK, len, 1'($urandom_range(1)), 1'b0, src_pos);
      end
      default: begin  // wrong item kind
        pick = $urandom_range(2);
        if (pick == 0) begin
          pull();
        end else if (pick == 1) begin
          feed({lzsd_pkg::KIND_FILL, 5'd3});
          feed(8'($urandom_range(255)));
          feed(8'($urandom_range(255)));
        end else begin
          feed({lzsd_pkg::KIND_LIT, 5'd3});
          pull();
        end
      end
    endcase
    repeat (12) send_beat(1'($urandom_range(1)), 8'($urandom_range(255)));
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst              = 1'b1;
    stream.valid     = 1'b0;
    stream.func      = lzsd_pkg::FUNC_FEED;
    stream.data_byte = 8'h00;
    hold_off_req     = 1'b0;
    mismatches       = 0;
    stream_beats     = 0;
    feed_idle_pct    = 0;
    result_stall_pct = 0;
    wr_pos           = 0;
    phase            = AWAIT_CMD;
    run_kind         = lzsd_pkg::KIND_LIT;
    run_left         = 0;
    src              = 16'h0000;
    pair             = 16'h0000;
    sticky_err       = lzsd_pkg::ERR_NONE;
    done             = 1'b0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_random_stream();
    test_backpressure();
    test_stream_end();

    stream.valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("lz_seven_command_decompressor_top_tb OK");
    end else begin
      $display("lz_seven_command_decompressor_top_tb NOT OK");
    end
    $finish;
  end

endmodule
